// File: hdl/cmv_pkg.sv
// cmv_pkg: shared types, constants and small tables for the cylinder vertex generator.
// Used by cmv_div, cmv_cordic, cmv_seq and cylinder_mesh_vertex_gen. No dependencies.
package cmv_pkg;

  localparam int unsigned FRAC_BITS     = 12;
  localparam int unsigned MAX_DIVISIONS = 1024;
  localparam int unsigned IDX_W         = 10;
  localparam int unsigned DIV_W         = 11;
  localparam int unsigned RAD_W         = 16;
  localparam int unsigned POS_W         = 17;
  localparam int unsigned Y_W           = 13;
  localparam int unsigned TEX_W         = 13;
  localparam int unsigned PH_W          = 32;
  localparam int unsigned CW            = 33;  // CORDIC datapath width
  localparam int unsigned CORDIC_STEPS  = 16;
  localparam int unsigned CORDIC_PER_ST = 2;
  localparam int unsigned DIV_STAGES    = 5;
  localparam longint     CORDIC_X0      = 652032874;
  localparam longint     UNIT30         = 64'sd1 << 30;
  localparam int unsigned CFG_W         = 16;

  localparam logic [TEX_W-1:0] HALF_FX = TEX_W'(1 << (FRAC_BITS - 1));
  localparam logic [TEX_W-1:0] ONE_FX  = TEX_W'(1 << FRAC_BITS);
  localparam logic signed [Y_W-1:0] Y_BOTTOM = -$signed(Y_W'(1 << (FRAC_BITS - 1)));

  localparam logic [3:0] FIRST_CAP  = 4'd0;
  localparam logic [3:0] FIRST_SIDE = 4'd6;
  localparam logic [3:0] LAST_IDX   = 4'd11;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_RADIAL = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_BOTTOM = 2'd0,
    KIND_TOP    = 2'd1,
    KIND_LOWER  = 2'd2,
    KIND_UPPER  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {PT_CENTER, PT_CUR, PT_NEXT} pt_e;
  typedef enum logic [1:0] {VS_ZERO, VS_ONE, VS_V0, VS_V1} vs_e;

  typedef struct packed {
    pt_e        pt;
    vs_e        vs;
    kind_e      kind;
    logic [1:0] corner;
  } vtx_t;

  typedef struct packed {
    logic [TEX_W-1:0] u;
    logic [TEX_W-1:0] nu;
    logic [TEX_W-1:0] v0;
    logic [TEX_W-1:0] v1;
    logic             jzero;
  } tex_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x0;
    logic signed [POS_W-1:0] z0;
    logic signed [POS_W-1:0] x1;
    logic signed [POS_W-1:0] z1;
    tex_t                    tex;
  } item_t;

  // Vertex recipe: caps first (indices 0-5), then the two side triangles (6-11).
  function automatic vtx_t vtx_of(input logic [3:0] k);
    vtx_t v;
    case (k)
      4'd0:    v = '{PT_CENTER, VS_ZERO, KIND_BOTTOM, 2'd0};
      4'd1:    v = '{PT_NEXT,   VS_ZERO, KIND_BOTTOM, 2'd1};
      4'd2:    v = '{PT_CUR,    VS_ZERO, KIND_BOTTOM, 2'd2};
      4'd3:    v = '{PT_CENTER, VS_ONE,  KIND_TOP,    2'd0};
      4'd4:    v = '{PT_CUR,    VS_ONE,  KIND_TOP,    2'd1};
      4'd5:    v = '{PT_NEXT,   VS_ONE,  KIND_TOP,    2'd2};
      4'd6:    v = '{PT_CUR,    VS_V0,   KIND_LOWER,  2'd0};
      4'd7:    v = '{PT_NEXT,   VS_V0,   KIND_LOWER,  2'd1};
      4'd8:    v = '{PT_CUR,    VS_V1,   KIND_LOWER,  2'd2};
      4'd9:    v = '{PT_CUR,    VS_V1,   KIND_UPPER,  2'd0};
      4'd10:   v = '{PT_NEXT,   VS_V0,   KIND_UPPER,  2'd1};
      default: v = '{PT_NEXT,   VS_V1,   KIND_UPPER,  2'd2};
    endcase
    return v;
  endfunction

  // Arctangent of 2^-k in units of 2^-32 turns.
  function automatic logic [31:0] atan_of(input int unsigned k);
    logic [31:0] a;
    case (k)
      0:       a = 32'd536870912;
      1:       a = 32'd316933406;
      2:       a = 32'd167458908;
      3:       a = 32'd85004756;
      4:       a = 32'd42667335;
      5:       a = 32'd21354465;
      6:       a = 32'd10679838;
      7:       a = 32'd5340245;
      8:       a = 32'd2670163;
      9:       a = 32'd1335087;
      10:      a = 32'd667544;
      11:      a = 32'd333772;
      12:      a = 32'd166886;
      13:      a = 32'd83443;
      14:      a = 32'd41722;
      default: a = 32'd20861;
    endcase
    return a;
  endfunction

endpackage

// File: hdl/cmv_div.sv
// cmv_div: pipelined restoring divider, several quotient bits per stage.
// Depends on cmv_pkg. Divisor must stay put while transactions are in flight.
module cmv_div #(
  parameter int unsigned LW     = 33,
  parameter int unsigned STAGES = 5
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [cmv_pkg::DIV_W-1:0] hi_i,   // upper dividend bits, below den_i
  input  logic [LW-1:0]             lo_i,
  input  logic [cmv_pkg::DIV_W-1:0] den_i,
  output logic [LW-1:0]             quo_o
);

  localparam int unsigned DW  = cmv_pkg::DIV_W;
  localparam int unsigned BPS = (LW + STAGES - 1) / STAGES;
  localparam int unsigned PW  = BPS * STAGES;

  logic [DW-1:0] rem_in [STAGES];
  logic [PW-1:0] num_in [STAGES];
  logic [DW-1:0] rem_d  [STAGES];
  logic [PW-1:0] num_d  [STAGES];
  logic [DW-1:0] rem_q  [STAGES];
  logic [PW-1:0] num_q  [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_st
    if (s == 0) begin : g_first
      // low part left-aligned; the first stage skips the pad bits
      assign rem_in[s] = hi_i;
      assign num_in[s] = PW'(lo_i) << (PW - LW);
    end else begin : g_next
      assign rem_in[s] = rem_q[s-1];
      assign num_in[s] = num_q[s-1];
    end

    always_comb begin : step
      logic [DW:0]   r2;
      logic [DW-1:0] r;
      logic [PW-1:0] q;
      r  = rem_in[s];
      q  = num_in[s];
      r2 = '0;
      for (int b = 0; b < BPS; b++) begin
        if (s > 0 || b >= int'(PW - LW)) begin
          r2 = {r, q[PW-1]};
          q  = {q[PW-2:0], 1'b0};
          if (r2 >= {1'b0, den_i}) begin
            r2   = r2 - {1'b0, den_i};
            q[0] = 1'b1;
          end
          r = r2[DW-1:0];
        end
      end
      rem_d[s] = r;
      num_d[s] = q;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d[s];
        num_q[s] <= num_d[s];
      end
    end
  end

  assign quo_o = num_q[STAGES-1][LW-1:0];

endmodule

// File: hdl/cmv_cordic.sv
// cmv_cordic: two-lane pipelined rotation CORDIC, quadrant fold, clamp and radius scale.
// Depends on cmv_pkg. Carries a valid bit and a payload tag alongside.
module cmv_cordic #(
  parameter int unsigned TW = 53
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [cmv_pkg::PH_W-1:0]         ph0_i,
  input  logic [cmv_pkg::PH_W-1:0]         ph1_i,
  input  logic [cmv_pkg::RAD_W-1:0]        rad_i,
  input  logic [TW-1:0]                    tag_i,
  output logic                             valid_o,
  output logic [TW-1:0]                    tag_o,
  output logic signed [cmv_pkg::POS_W-1:0] x_o [2],
  output logic signed [cmv_pkg::POS_W-1:0] z_o [2]
);

  localparam int unsigned CW  = cmv_pkg::CW;
  localparam int unsigned PS  = cmv_pkg::CORDIC_PER_ST;
  localparam int unsigned NIT = cmv_pkg::CORDIC_STEPS / PS;
  localparam int unsigned NST = NIT + 3;
  localparam int unsigned PWD = cmv_pkg::POS_W;
  localparam int unsigned MW  = cmv_pkg::RAD_W + 1 + 32;
  localparam logic signed [CW-1:0] UNIT = CW'(cmv_pkg::UNIT30);
  localparam logic signed [MW-1:0] RND  = MW'(64'sd1 << 29);

  logic signed [CW-1:0]  x_q  [2][NIT+1];
  logic signed [CW-1:0]  y_q  [2][NIT+1];
  logic signed [CW-1:0]  z_q  [2][NIT+1];
  logic [1:0]            qd_q [2][NIT+1];
  logic signed [31:0]    c_q  [2];
  logic signed [31:0]    s_q  [2];
  logic signed [PWD-1:0] xo_q [2];
  logic signed [PWD-1:0] zo_q [2];
  logic                  vld_q [NST];
  logic [TW-1:0]         tag_q [NST];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [cmv_pkg::PH_W-1:0] ph;
    assign ph = (l == 0) ? ph0_i : ph1_i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        qd_q[l][0] <= ph[31:30];
        x_q[l][0]  <= CW'(cmv_pkg::CORDIC_X0);
        y_q[l][0]  <= '0;
        z_q[l][0]  <= CW'(ph[29:0]);
      end
    end

    for (genvar s = 1; s <= NIT; s++) begin : g_it
      logic signed [CW-1:0] xn, yn, zn;

      always_comb begin : rot
        logic signed [CW-1:0] dx, dy, at;
        int unsigned          k;
        xn = x_q[l][s-1];
        yn = y_q[l][s-1];
        zn = z_q[l][s-1];
        for (int b = 0; b < PS; b++) begin
          k  = (s - 1) * PS + b;
          dx = yn >>> k;
          dy = xn >>> k;
          at = $signed({1'b0, cmv_pkg::atan_of(k)});
          if (!zn[CW-1]) begin
            xn = xn - dx;
            yn = yn + dy;
            zn = zn - at;
          end else begin
            xn = xn + dx;
            yn = yn - dy;
            zn = zn + at;
          end
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[l][s]  <= xn;
          y_q[l][s]  <= yn;
          z_q[l][s]  <= zn;
          qd_q[l][s] <= qd_q[l][s-1];
        end
      end
    end

    // Clamp to +-1.0 and fold into the quadrant.
    logic signed [CW-1:0] cx, cy, cf, sf;
    always_comb begin
      cx = (x_q[l][NIT] > UNIT) ? UNIT : ((x_q[l][NIT] < -UNIT) ? -UNIT : x_q[l][NIT]);
      cy = (y_q[l][NIT] > UNIT) ? UNIT : ((y_q[l][NIT] < -UNIT) ? -UNIT : y_q[l][NIT]);
      case (qd_q[l][NIT])
        2'd0: begin cf = cx;  sf = cy;  end
        2'd1: begin cf = -cy; sf = cx;  end
        2'd2: begin cf = -cx; sf = -cy; end
        default: begin cf = cy; sf = -cx; end
      endcase
    end

    // radius * trig, round half up, floor shift by 30.
    logic signed [MW-1:0] px, pz;
    always_comb begin
      px = $signed({1'b0, rad_i}) * c_q[l] + RND;
      pz = $signed({1'b0, rad_i}) * s_q[l] + RND;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        c_q[l]  <= cf[31:0];
        s_q[l]  <= sf[31:0];
        xo_q[l] <= px[30+PWD-1:30];
        zo_q[l] <= pz[30+PWD-1:30];
      end
    end

    assign x_o[l] = xo_q[l];
    assign z_o[l] = zo_q[l];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NST; s++) vld_q[s] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int s = 1; s < NST; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
      for (int s = 1; s < NST; s++) tag_q[s] <= tag_q[s-1];
    end
  end

  assign valid_o = vld_q[NST-1];
  assign tag_o   = tag_q[NST-1];

endmodule

// File: hdl/cmv_seq.sv
// cmv_seq: holds one finished item and sends its vertices, one per cycle.
// Depends on cmv_pkg (vertex recipe, item type).
module cmv_seq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  cmv_pkg::item_t                   item_i,
  output logic                             ready_o,
  output logic                             vtx_valid_o,
  output logic signed [cmv_pkg::POS_W-1:0] pos_x_o,
  output logic signed [cmv_pkg::Y_W-1:0]   pos_y_o,
  output logic signed [cmv_pkg::POS_W-1:0] pos_z_o,
  output logic [cmv_pkg::TEX_W-1:0]        tex_u_o,
  output logic [cmv_pkg::TEX_W-1:0]        tex_v_o,
  output logic [1:0]                       tri_kind_o,
  output logic [1:0]                       corner_o,
  output logic                             last_vertex_o
);

  localparam int unsigned TW = cmv_pkg::TEX_W;

  logic                 active_q;
  logic [3:0]           cnt_q;
  cmv_pkg::item_t       item_q;
  logic                 valid_q, last_q;
  logic signed [cmv_pkg::POS_W-1:0] x_q, z_q;
  logic signed [cmv_pkg::Y_W-1:0]   y_q;
  logic [TW-1:0]        u_q, v_q;
  logic [1:0]           kind_q, corner_q;

  cmv_pkg::vtx_t                    vtx;
  logic                             last;
  logic signed [cmv_pkg::POS_W-1:0] x_d, z_d;
  logic [TW-1:0]                    u_d, v_d;
  logic signed [TW:0]               yw;

  always_comb begin
    vtx  = cmv_pkg::vtx_of(cnt_q);
    last = (cnt_q == cmv_pkg::LAST_IDX);
    case (vtx.pt)
      cmv_pkg::PT_CUR:  begin x_d = item_q.x0; z_d = item_q.z0; u_d = item_q.tex.u;  end
      cmv_pkg::PT_NEXT: begin x_d = item_q.x1; z_d = item_q.z1; u_d = item_q.tex.nu; end
      default:          begin x_d = '0;        z_d = '0;        u_d = item_q.tex.u;  end
    endcase
    case (vtx.vs)
      cmv_pkg::VS_ONE: v_d = cmv_pkg::ONE_FX;
      cmv_pkg::VS_V0:  v_d = item_q.tex.v0;
      cmv_pkg::VS_V1:  v_d = item_q.tex.v1;
      default:         v_d = '0;
    endcase
    // y tracks v: y = v - 0.5
    yw = $signed({1'b0, v_d}) - $signed({1'b0, cmv_pkg::HALF_FX});
  end

  assign ready_o = !active_q || last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
      valid_q  <= 1'b0;
    end else begin
      valid_q <= active_q;
      if (load_i) begin
        active_q <= 1'b1;
        cnt_q    <= item_i.tex.jzero ? cmv_pkg::FIRST_CAP : cmv_pkg::FIRST_SIDE;
      end else if (active_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (last) active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) item_q <= item_i;
    if (active_q) begin
      x_q      <= x_d;
      y_q      <= yw[cmv_pkg::Y_W-1:0];
      z_q      <= z_d;
      u_q      <= u_d;
      v_q      <= v_d;
      kind_q   <= vtx.kind;
      corner_q <= vtx.corner;
      last_q   <= last;
    end
  end

  assign vtx_valid_o   = valid_q;
  assign pos_x_o       = x_q;
  assign pos_y_o       = y_q;
  assign pos_z_o       = z_q;
  assign tex_u_o       = u_q;
  assign tex_v_o       = v_q;
  assign tri_kind_o    = kind_q;
  assign corner_o      = corner_q;
  assign last_vertex_o = last_q;

endmodule

// File: hdl/cylinder_mesh_vertex_gen.sv
// cylinder_mesh_vertex_gen: cylinder tessellator top level, config registers and pipeline glue.
// Depends on cmv_pkg, cmv_div, cmv_cordic, cmv_seq.
//
//  channel   | signals                                     | transfer
//  ----------+---------------------------------------------+------------------------------
//  command   | start, busy, slice_index_i, band_index_i    | start && !busy
//  vertex    | vtx_valid_o, pos_*_o, tex_*_o, tri_kind_o,  | one cycle per strobe, no hold
//            | corner_o, last_vertex_o                     |
//  config    | cfg_we_i, cfg_idx_i, cfg_wdata_i            | cfg_we_i
//
// One vertex leaves per cycle: 6 vertices per item, 12 on band zero (caps).
// The first vertex of a command passes 5 divider stages, 11 CORDIC/scale
// stages, the vertex sequencer and its output register.
// busy rises when the pipeline tail holds an item the sequencer cannot take yet;
// the divider and CORDIC stages then hold. Out-of-range items travel as bubbles.
// Reset clears valid bits and loads radius 1.0, 16 slices, 1 band.
module cylinder_mesh_vertex_gen (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [cmv_pkg::IDX_W-1:0]        slice_index_i,
  input  logic [cmv_pkg::IDX_W-1:0]        band_index_i,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_idx_i,
  input  logic [cmv_pkg::CFG_W-1:0]        cfg_wdata_i,
  output logic                             vtx_valid_o,
  output logic signed [cmv_pkg::POS_W-1:0] pos_x_o,
  output logic signed [cmv_pkg::Y_W-1:0]   pos_y_o,
  output logic signed [cmv_pkg::POS_W-1:0] pos_z_o,
  output logic [cmv_pkg::TEX_W-1:0]        tex_u_o,
  output logic [cmv_pkg::TEX_W-1:0]        tex_v_o,
  output logic [1:0]                       tri_kind_o,
  output logic [1:0]                       corner_o,
  output logic                             last_vertex_o
);

  localparam int unsigned DW = cmv_pkg::DIV_W;
  localparam int unsigned FB = cmv_pkg::FRAC_BITS;
  localparam int unsigned DS = cmv_pkg::DIV_STAGES;
  localparam int unsigned PL = cmv_pkg::PH_W + 1;
  localparam int unsigned TL = cmv_pkg::TEX_W;
  localparam logic [DW-1:0] MAXD = DW'(cmv_pkg::MAX_DIVISIONS);

  logic [cmv_pkg::RAD_W-1:0] radius_q;
  logic [DW-1:0]             radial_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= cmv_pkg::RAD_W'(4096);
      radial_q <= DW'(16);
      height_q <= DW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cmv_pkg::REG_RADIUS: radius_q <= cfg_wdata_i;
        cmv_pkg::REG_RADIAL: radial_q <= cfg_wdata_i[DW-1:0];
        cmv_pkg::REG_HEIGHT: height_q <= cfg_wdata_i[DW-1:0];
        default: ;
      endcase
    end
  end

  logic [DW-1:0] n_sat, h_sat, i1, j1;
  logic          in_ok, adv;

  assign n_sat = (radial_q > MAXD) ? MAXD : radial_q;
  assign h_sat = (height_q > MAXD) ? MAXD : height_q;
  assign i1    = {1'b0, slice_index_i} + DW'(1);
  assign j1    = {1'b0, band_index_i} + DW'(1);
  assign adv   = !busy;
  assign in_ok = start && !busy && ({1'b0, slice_index_i} < n_sat)
                 && ({1'b0, band_index_i} < h_sat);

  // Dividend = (k << bits) + N/2, split so the high part stays below N.
  logic [PL-1:0] ph0_q, ph1_q;
  logic [TL-1:0] u_q, nu_q, v0_q, v1_q;

  cmv_div #(.LW(PL), .STAGES(DS)) u_ph0 (
    .clk_i, .en_i(adv), .hi_i({2'b0, slice_index_i[9:1]}),
    .lo_i({slice_index_i[0], (PL-1)'(n_sat >> 1)}), .den_i(n_sat), .quo_o(ph0_q));
  cmv_div #(.LW(PL), .STAGES(DS)) u_ph1 (
    .clk_i, .en_i(adv), .hi_i({1'b0, i1[DW-1:1]}),
    .lo_i({i1[0], (PL-1)'(n_sat >> 1)}), .den_i(n_sat), .quo_o(ph1_q));
  cmv_div #(.LW(TL), .STAGES(DS)) u_u0 (
    .clk_i, .en_i(adv), .hi_i({2'b0, slice_index_i[9:1]}),
    .lo_i({slice_index_i[0], FB'(n_sat >> 1)}), .den_i(n_sat), .quo_o(u_q));
  cmv_div #(.LW(TL), .STAGES(DS)) u_u1 (
    .clk_i, .en_i(adv), .hi_i({1'b0, i1[DW-1:1]}),
    .lo_i({i1[0], FB'(n_sat >> 1)}), .den_i(n_sat), .quo_o(nu_q));
  cmv_div #(.LW(TL), .STAGES(DS)) u_v0 (
    .clk_i, .en_i(adv), .hi_i({2'b0, band_index_i[9:1]}),
    .lo_i({band_index_i[0], FB'(h_sat >> 1)}), .den_i(h_sat), .quo_o(v0_q));
  cmv_div #(.LW(TL), .STAGES(DS)) u_v1 (
    .clk_i, .en_i(adv), .hi_i({1'b0, j1[DW-1:1]}),
    .lo_i({j1[0], FB'(h_sat >> 1)}), .den_i(h_sat), .quo_o(v1_q));

  logic dv_q [DS];
  logic jz_q [DS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DS; s++) dv_q[s] <= 1'b0;
    end else if (adv) begin
      dv_q[0] <= in_ok;
      for (int s = 1; s < DS; s++) dv_q[s] <= dv_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      jz_q[0] <= (band_index_i == '0);
      for (int s = 1; s < DS; s++) jz_q[s] <= jz_q[s-1];
    end
  end

  cmv_pkg::tex_t tex_in, tex_out;
  logic          crd_valid, seq_ready;
  logic signed [cmv_pkg::POS_W-1:0] cx [2];
  logic signed [cmv_pkg::POS_W-1:0] cz [2];
  cmv_pkg::item_t item;

  assign tex_in = '{u: u_q, nu: nu_q, v0: v0_q, v1: v1_q, jzero: jz_q[DS-1]};

  cmv_cordic #(.TW($bits(cmv_pkg::tex_t))) u_cordic (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(dv_q[DS-1]),
    .ph0_i(ph0_q[cmv_pkg::PH_W-1:0]), .ph1_i(ph1_q[cmv_pkg::PH_W-1:0]),
    .rad_i(radius_q), .tag_i(tex_in), .valid_o(crd_valid), .tag_o(tex_out),
    .x_o(cx), .z_o(cz));

  assign item = '{x0: cx[0], z0: cz[0], x1: cx[1], z1: cz[1], tex: tex_out};
  assign busy = crd_valid && !seq_ready;

  cmv_seq u_seq (
    .clk_i, .rst_ni, .load_i(crd_valid && adv), .item_i(item), .ready_o(seq_ready),
    .vtx_valid_o, .pos_x_o, .pos_y_o, .pos_z_o, .tex_u_o, .tex_v_o,
    .tri_kind_o, .corner_o, .last_vertex_o);

  a_last_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtx_valid_o && last_vertex_o |-> tri_kind_o == cmv_pkg::KIND_UPPER && corner_o == 2'd2)
    else $error("item did not end on upper side corner 2");

  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtx_valid_o && !last_vertex_o |=> vtx_valid_o)
    else $error("gap inside an item's vertex burst");

  a_bottom_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtx_valid_o && tri_kind_o == cmv_pkg::KIND_BOTTOM |-> pos_y_o == cmv_pkg::Y_BOTTOM)
    else $error("bottom cap vertex off the bottom plane");

endmodule
